FILE: rtl/core/k_subset_combination_generator_unit_macros.svh
// assertion helpers for the combination generator, clocked on clk, off during reset
`ifndef K_SUBSET_COMBINATION_GENERATOR_UNIT_MACROS_SVH
`define K_SUBSET_COMBINATION_GENERATOR_UNIT_MACROS_SVH

// property that must hold at every edge
`define KSCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence in the cycle after a trigger
`define KSCG_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/core/kscg_pkg.sv
package kscg_pkg;

  localparam int DEF_MAX_SET      = 16;
  localparam int DEF_ELEMENT_BITS = 16;

  localparam int CC_W      = 5;   // choose_count width
  localparam int CFG_IDX_W = 1;
  localparam int ACT_W     = 2;
  localparam int NUM_W     = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_CHOOSE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING   = 1'd1;

  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_YIELD   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE,
    CELL_MASK,
    CELL_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     descending;
    logic     phase;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/kscg_cell.sv
module kscg_cell #(
  parameter int MAX_SET      = kscg_pkg::DEF_MAX_SET,
  parameter int ELEMENT_BITS = kscg_pkg::DEF_ELEMENT_BITS,
  parameter int CELL_IDX     = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kscg_pkg::cell_ctrl_t             ctrl,
  input  logic [$clog2(MAX_SET+1)-1:0]     n,
  input  logic [$clog2(MAX_SET+1)-1:0]     keep_below,
  input  logic [$clog2(MAX_SET+1)-1:0]     lo,
  input  logic [$clog2(MAX_SET+1)-1:0]     hi,
  input  logic signed [ELEMENT_BITS-1:0]   new_val,
  input  logic signed [ELEMENT_BITS-1:0]   left_val,
  input  logic                             left_g,
  input  logic signed [ELEMENT_BITS-1:0]   right_val,
  input  logic                             right_bit,
  input  logic signed [ELEMENT_BITS-1:0]   head_val,
  input  logic                             head_bit,
  output logic signed [ELEMENT_BITS-1:0]   val_o,
  output logic                             bit_o,
  output logic                             g_o
);

  localparam int CNT_W = $clog2(MAX_SET+1);
  localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_IDX);

  logic signed [ELEMENT_BITS-1:0] val_r, val_nxt;
  logic                           bit_r, bit_nxt;
  logic                           cmp_ins, mask_new;
  logic                           r_act, r_swap, l_act, l_swap;

  always_comb begin
    cmp_ins  = ctrl.descending ? (val_r < new_val) : (val_r > new_val);
    g_o      = (IDX >= n) || cmp_ins;
    mask_new = (IDX < keep_below) ? bit_r : ((IDX >= lo) && (IDX < hi));

    // odd-even transposition: pair with right or left neighbor by phase
    r_act  = (IDX[0] == ctrl.phase) && ((IDX + CNT_W'(1)) < n);
    r_swap = r_act && (ctrl.descending ? (val_r < right_val) : (val_r > right_val));
    l_act  = (IDX[0] != ctrl.phase) && (IDX != '0) && (IDX < n);
    l_swap = l_act && (ctrl.descending ? (left_val < val_r) : (left_val > val_r));

    val_nxt = val_r;
    bit_nxt = bit_r;
    unique case (ctrl.op)
      kscg_pkg::CELL_HOLD: begin
      end
      kscg_pkg::CELL_INSERT: begin
        if (g_o) begin
          val_nxt = left_g ? left_val : new_val;
        end
        bit_nxt = mask_new;
      end
      kscg_pkg::CELL_ROTATE: begin
        if (IDX < n) begin
          if ((IDX + CNT_W'(1)) == n) begin
            val_nxt = head_val;
          end else begin
            val_nxt = right_val;
          end
        end
      end
      kscg_pkg::CELL_MASK: begin
        bit_nxt = mask_new;
      end
      kscg_pkg::CELL_SORT: begin
        if (r_swap) begin
          val_nxt = right_val;
        end else if (l_swap) begin
          val_nxt = left_val;
        end
      end
      default: begin
      end
    endcase
  end

  // mask bit of the rotation travels with the data; kept separate from the value
  logic rot_bit;
  always_comb begin
    rot_bit = bit_nxt;
    if ((ctrl.op == kscg_pkg::CELL_ROTATE) && (IDX < n)) begin
      rot_bit = ((IDX + CNT_W'(1)) == n) ? head_bit : right_bit;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else begin
      bit_r <= rot_bit;
    end
  end

  assign val_o = val_r;
  assign bit_o = bit_r;

endmodule

FILE: rtl/core/k_subset_combination_generator_unit.sv
// k-element combination generator over a sorted set of up to MAX_SET signed elements.
// A row of MAX_SET cells holds the set in sorted order (ascending, or descending
// when the descending register is 1) together with the selection mask, one element
// and one mask bit per cell. A load inserts one element (every cell compares
// against the new value and shifts right from the insertion point) and restarts
// at the first combination. A yield walks the row by rotating it past the head
// cell, one position per cycle unless a beat waits on the result side, and sends one
// beat per chosen element with the running decimal number, then steps the mask to
// the previous permutation; an empty combination sends a single empty beat.
// Changing the descending register latches the change, rewinds the mask once the
// unit is idle, then re-sorts the row by odd-even transposition, one neighbor
// exchange per cell per cycle: no item is taken until the re-sort ends;
// configuration writes are taken in any cycle.
module k_subset_combination_generator_unit #(
  parameter int MAX_SET      = kscg_pkg::DEF_MAX_SET,
  parameter int ELEMENT_BITS = kscg_pkg::DEF_ELEMENT_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration port
  input  logic                                 cfg_we,
  input  logic [kscg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kscg_pkg::CC_W-1:0]            cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [kscg_pkg::ACT_W-1:0]           in_action,
  input  logic signed [ELEMENT_BITS-1:0]       in_element_value,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ELEMENT_BITS-1:0]       out_chosen_element,
  output logic [kscg_pkg::NUM_W-1:0]           out_running_number,
  output logic                                 out_is_empty,
  output logic                                 out_last_of_run
);

`include "k_subset_combination_generator_unit_macros.svh"

  localparam int CNT_W = $clog2(MAX_SET+1);
  localparam int IDX_W = $clog2(MAX_SET);
  localparam int KW    = (CNT_W > kscg_pkg::CC_W) ? CNT_W : kscg_pkg::CC_W;
  localparam int NUM_W = kscg_pkg::NUM_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_SORT
  } state_t;

  // k saturated to the set size
  function automatic logic [CNT_W-1:0] kmin(input logic [kscg_pkg::CC_W-1:0] c,
                                            input logic [CNT_W-1:0] s);
    logic [KW-1:0] ce;
    logic [KW-1:0] se;
    ce = KW'(c);
    se = KW'(s);
    kmin = (ce < se) ? CNT_W'(c) : s;
  endfunction

  state_t                          state_r;
  logic [CNT_W-1:0]                size_r;
  logic [CNT_W-1:0]                ones_r;     // set bits in the mask
  logic [kscg_pkg::CC_W-1:0]       cc_r;
  logic                            desc_r;
  logic                            pend_r;     // re-sort and restart waiting
  logic [CNT_W-1:0]                pend_k_r;
  logic [IDX_W-1:0]                phase_r;
  // scan bookkeeping
  logic [IDX_W-1:0]                pos_r;
  logic                            prev_r;
  logic                            found_r;
  logic [IDX_W-1:0]                brk_r;      // last set bit followed by a clear one
  logic [CNT_W-1:0]                p1_r;       // set bits up to and including brk_r
  logic [CNT_W-1:0]                seen_r;
  logic [NUM_W-1:0]                num_r;
  // output register
  logic                            out_valid_r;
  logic signed [ELEMENT_BITS-1:0]  out_elem_r;
  logic [NUM_W-1:0]                out_num_r;
  logic                            out_empty_r;
  logic                            out_last_r;

  kscg_pkg::cell_ctrl_t            ctrl;
  logic [CNT_W-1:0]                keep_c, lo_c, hi_c;
  logic [CNT_W-1:0]                k_now, k_ins;
  logic                            desc_chg, in_acc, out_free, advance, full;
  logic                            beat_go;
  logic signed [ELEMENT_BITS-1:0]  head_val;
  logic                            head_bit;
  logic [NUM_W-1:0]                num_nxt;

  logic signed [ELEMENT_BITS-1:0]  val_w [MAX_SET];
  logic [MAX_SET-1:0]              bit_w;
  logic [MAX_SET-1:0]              g_w;
  logic signed [ELEMENT_BITS-1:0]  lval_w [MAX_SET];
  logic signed [ELEMENT_BITS-1:0]  rval_w [MAX_SET];
  logic [MAX_SET-1:0]              lg_w;
  logic [MAX_SET-1:0]              rbit_w;

  assign desc_chg = cfg_we && (cfg_index == kscg_pkg::CFG_DESCENDING) && (cfg_data[0] != desc_r);
  assign in_ready = (state_r == ST_IDLE) && !pend_r && !desc_chg;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign head_val = val_w[0];
  assign head_bit = bit_w[0];
  // a clear head bit passes without a beat
  assign advance  = !head_bit || out_free;
  // a new beat enters the output register this cycle
  assign beat_go  = (state_r == ST_SCAN) && ((ones_r == '0) ? out_free : (advance && head_bit));
  assign full     = (size_r == CNT_W'(MAX_SET));
  assign k_now    = kmin(cc_r, size_r);
  assign k_ins    = kmin(cc_r, size_r + CNT_W'(1));
  // number * 10 + element, element sign-extended
  assign num_nxt  = (num_r << 3) + (num_r << 1)
                  + {{(NUM_W-ELEMENT_BITS){head_val[ELEMENT_BITS-1]}}, head_val};

  // command for the cell row
  always_comb begin
    ctrl.op         = kscg_pkg::CELL_HOLD;
    ctrl.descending = desc_r;
    ctrl.phase      = phase_r[0];
    keep_c          = '0;
    lo_c            = '0;
    hi_c            = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (pend_r) begin
          ctrl.op = kscg_pkg::CELL_MASK;
          hi_c    = pend_k_r;
        end else if (in_acc) begin
          if (in_action == kscg_pkg::ACT_LOAD) begin
            // a full set drops the element but still restarts
            ctrl.op = full ? kscg_pkg::CELL_MASK : kscg_pkg::CELL_INSERT;
            hi_c    = full ? k_now : k_ins;
          end else if (in_action == kscg_pkg::ACT_RESTART) begin
            ctrl.op = kscg_pkg::CELL_MASK;
            hi_c    = k_now;
          end
        end
      end
      ST_SCAN: begin
        if ((ones_r != '0) && advance) begin
          ctrl.op = kscg_pkg::CELL_ROTATE;
        end
      end
      ST_UPD: begin
        // previous permutation: clear the break bit, pack the tail ones after it
        ctrl.op = kscg_pkg::CELL_MASK;
        if (found_r) begin
          keep_c = CNT_W'(brk_r);
          lo_c   = CNT_W'(brk_r) + CNT_W'(1);
          hi_c   = CNT_W'(brk_r) + (ones_r - p1_r) + CNT_W'(2);
        end else begin
          // last combination wraps to the first
          hi_c   = ones_r;
        end
      end
      ST_SORT: begin
        ctrl.op = kscg_pkg::CELL_SORT;
      end
      default: begin
      end
    endcase
  end

  // neighbor wiring of the row
  for (genvar gi = 0; gi < MAX_SET; gi++) begin : g_link
    if (gi == 0) begin : g_first
      assign lval_w[gi] = in_element_value;
      assign lg_w[gi]   = 1'b0;
    end else begin : g_mid_l
      assign lval_w[gi] = val_w[gi-1];
      assign lg_w[gi]   = g_w[gi-1];
    end
    if (gi == MAX_SET-1) begin : g_last
      assign rval_w[gi] = val_w[gi];
      assign rbit_w[gi] = bit_w[gi];
    end else begin : g_mid_r
      assign rval_w[gi] = val_w[gi+1];
      assign rbit_w[gi] = bit_w[gi+1];
    end

    kscg_cell #(
      .MAX_SET      (MAX_SET),
      .ELEMENT_BITS (ELEMENT_BITS),
      .CELL_IDX     (gi)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .n          (size_r),
      .keep_below (keep_c),
      .lo         (lo_c),
      .hi         (hi_c),
      .new_val    (in_element_value),
      .left_val   (lval_w[gi]),
      .left_g     (lg_w[gi]),
      .right_val  (rval_w[gi]),
      .right_bit  (rbit_w[gi]),
      .head_val   (head_val),
      .head_bit   (head_bit),
      .val_o      (val_w[gi]),
      .bit_o      (bit_w[gi]),
      .g_o        (g_w[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= '0;
      ones_r      <= '0;
      cc_r        <= '0;
      desc_r      <= 1'b0;
      pend_r      <= 1'b0;
      pend_k_r    <= '0;
      phase_r     <= '0;
      pos_r       <= '0;
      prev_r      <= 1'b0;
      found_r     <= 1'b0;
      brk_r       <= '0;
      p1_r        <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (beat_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pend_r) begin
            ones_r  <= pend_k_r;
            phase_r <= '0;
            state_r <= ST_SORT;
          end else if (in_acc) begin
            if (in_action == kscg_pkg::ACT_LOAD) begin
              if (!full) begin
                size_r <= size_r + CNT_W'(1);
                ones_r <= k_ins;
              end else begin
                ones_r <= k_now;
              end
            end else if (in_action == kscg_pkg::ACT_YIELD) begin
              pos_r   <= '0;
              prev_r  <= 1'b0;
              found_r <= 1'b0;
              seen_r  <= '0;
              num_r   <= '0;
              state_r <= ST_SCAN;
            end else if (in_action == kscg_pkg::ACT_RESTART) begin
              ones_r <= k_now;
            end
          end
        end
        ST_SCAN: begin
          if (ones_r == '0) begin
            // empty combination: a single beat
            if (out_free) begin
              out_elem_r  <= '0;
              out_num_r   <= '0;
              out_empty_r <= 1'b1;
              out_last_r  <= 1'b1;
              state_r     <= ST_UPD;
            end
          end else if (advance) begin
            if (head_bit) begin
              out_elem_r  <= head_val;
              out_num_r   <= num_nxt;
              out_empty_r <= 1'b0;
              out_last_r  <= (seen_r + CNT_W'(1)) == ones_r;
              num_r       <= num_nxt;
              seen_r      <= seen_r + CNT_W'(1);
            end
            if (prev_r && !head_bit) begin
              found_r <= 1'b1;
              brk_r   <= pos_r - IDX_W'(1);
              p1_r    <= seen_r;
            end
            prev_r <= head_bit;
            pos_r  <= pos_r + IDX_W'(1);
            if (CNT_W'(pos_r) == (size_r - CNT_W'(1))) begin
              state_r <= ST_UPD;
            end
          end
        end
        ST_UPD: begin
          state_r <= ST_IDLE;
        end
        ST_SORT: begin
          phase_r <= phase_r + IDX_W'(1);
          if (phase_r == IDX_W'(MAX_SET-1)) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // configuration; a change of order re-sorts the row and restarts
      if (cfg_we) begin
        unique case (cfg_index)
          kscg_pkg::CFG_CHOOSE_COUNT: begin
            cc_r <= cfg_data;
          end
          kscg_pkg::CFG_DESCENDING: begin
            if (desc_chg) begin
              desc_r   <= cfg_data[0];
              pend_k_r <= k_now;
            end
          end
          default: begin
          end
        endcase
      end

      // pending re-sort is raised by an order change, dropped once the row takes it
      if (desc_chg) begin
        pend_r <= 1'b1;
      end else if ((state_r == ST_IDLE) && pend_r) begin
        pend_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_chosen_element = out_elem_r;
  assign out_running_number = out_num_r;
  assign out_is_empty       = out_empty_r;
  assign out_last_of_run    = out_last_r;

  // checks
  `KSCG_ASSERT(a_ones_le_size, ones_r <= size_r, "mask holds more bits than the set")
  `KSCG_ASSERT(a_mask_count, (state_r != ST_IDLE) || pend_r || (CNT_W'($countones(bit_w)) == ones_r), "mask bit count lost")
  `KSCG_ASSERT_NEXT(a_yield_scans, in_acc && (in_action == kscg_pkg::ACT_YIELD), state_r == ST_SCAN, "yield did not start a scan")
  `KSCG_ASSERT_NEXT(a_size_grows, 1'b1, size_r >= $past(size_r), "set size shrank")

endmodule
